/* design/rqrm_pkg.sv */
// rqrm_pkg: shared sizes, codes and payload types of the ready queue.
// Used by every module of the ready queue and by its checker.
`default_nettype none

package rqrm_pkg;

   // Queue sizing
   localparam int DEPTH    = 16;
   localparam int ID_BITS  = 16;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // Action codes carried by a request
   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_REMOVE = 2'd2
   } action_type;

   // Status codes returned with each response
   typedef enum logic [1:0] {
      STS_DONE = 2'd0,
      STS_MISS = 2'd1,
      STS_FULL = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Request payload
   typedef struct packed {
      logic [1:0]         action;
      logic [ID_BITS-1:0] task_id;
   } req_type;

   // Response payload
   typedef struct packed {
      status_type          status;
      logic [ID_BITS-1:0]  removed_id;
      logic [CNT_BITS-1:0] entry_count;
   } rsp_type;

   // Command broadcast to every cell for one cycle
   typedef struct packed {
      logic               push;
      logic               pop;
      logic               remove;
      logic [ID_BITS-1:0] id;
   } cmd_type;

   // What the row of cells reports back to the sequencer
   typedef struct packed {
      logic               hit;
      logic [ID_BITS-1:0] hit_id;
      logic [ID_BITS-1:0] head_id;
   } row_stat_type;

endpackage

`default_nettype wire

/* design/rqrm_cell.sv */
// rqrm_cell: one queue slot; holds an identifier, compares it and shifts.
// Depends on rqrm_pkg for the command type and widths.
`default_nettype none

module rqrm_cell (
   input  wire logic                        clock,
   input  wire rqrm_pkg::cmd_type           cmd,
   input  wire logic                        occ,
   input  wire logic                        is_tail,
   input  wire logic                        hit_in,
   input  wire logic [rqrm_pkg::ID_BITS-1:0] found_id_in,
   input  wire logic [rqrm_pkg::ID_BITS-1:0] next_entry,
   output logic      [rqrm_pkg::ID_BITS-1:0] entry,
   output logic                             hit_out,
   output logic      [rqrm_pkg::ID_BITS-1:0] found_id_out
);
   import rqrm_pkg::*;

   logic [ID_BITS-1:0] entry_ff;
   logic [ID_BITS-1:0] entry_in;
   logic               match;

   // Compare against the removal key; only the first match counts
   assign match        = cmd.remove & occ & (entry_ff == cmd.id);
   assign hit_out      = hit_in | match;
   assign found_id_out = (match & ~hit_in) ? entry_ff : found_id_in;
   assign entry        = entry_ff;

   // Advance from the neighbour on pop or behind a removal, load on push at the tail
   always_comb begin
      if (cmd.pop | (cmd.remove & hit_out)) begin
         entry_in = next_entry;
      end else if (cmd.push & is_tail) begin
         entry_in = cmd.id;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

/* design/rqrm_row.sv */
// rqrm_row: the chain of queue cells, head at cell 0, with its neighbour links.
// Depends on rqrm_pkg and rqrm_cell.
`default_nettype none

module rqrm_row (
   input  wire logic                          clock,
   input  wire rqrm_pkg::cmd_type             cmd,
   input  wire logic [rqrm_pkg::CNT_BITS-1:0] count,
   output rqrm_pkg::row_stat_type             stat
);
   import rqrm_pkg::*;

   logic [ID_BITS-1:0] entry    [DEPTH];
   logic [ID_BITS-1:0] next_ent [DEPTH];
   logic [ID_BITS-1:0] found    [DEPTH+1];
   logic               hit      [DEPTH+1];

   // Chain starts with no match seen
   assign hit[0]   = 1'b0;
   assign found[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      // Hand each cell its upper neighbour; the last one takes don't-care zeros
      if (i == DEPTH - 1) begin : g_last
         assign next_ent[i] = '0;
      end else begin : g_mid
         assign next_ent[i] = entry[i+1];
      end

      rqrm_cell u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .occ          (CNT_BITS'(i) < count),
         .is_tail      (CNT_BITS'(i) == count),
         .hit_in       (hit[i]),
         .found_id_in  (found[i]),
         .next_entry   (next_ent[i]),
         .entry        (entry[i]),
         .hit_out      (hit[i+1]),
         .found_id_out (found[i+1])
      );
   end

   // Report the match and the head
   assign stat.hit     = hit[DEPTH];
   assign stat.hit_id  = found[DEPTH];
   assign stat.head_id = entry[0];

endmodule

`default_nettype wire

/* design/ready_queue_with_remove_by_id.sv */
// ready_queue_with_remove_by_id: ordered ready queue with push, pop and remove by id.
// Depends on rqrm_pkg and rqrm_row (which holds the rqrm_cell chain).
//
//   channel | ports                          | carries
//   --------+--------------------------------+---------------------------------
//   request | req_valid, req_stall, req      | action, task_id
//   response| rsp_valid, rsp_stall, rsp      | status, removed_id, entry_count
//
// Each request is first registered and then executed in S_EXEC, in which every cell
// compares and shifts in parallel. The response register is loaded at the end
// of S_EXEC; req_stall is high in S_EXEC, so no new request is taken while one executes.
// Reset empties the queue by clearing the count; cell contents are left as they are.
// A stalled response holds the request side off until it is taken.
`default_nettype none

module ready_queue_with_remove_by_id (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rqrm_pkg::req_type req,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rqrm_pkg::rsp_type      rsp
);
   import rqrm_pkg::*;

   state_type           state_ff, state_in;
   req_type             req_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                exec;
   logic                accept;
   logic                full, empty;
   cmd_type             cmd;
   row_stat_type        stat;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      case (state_ff)
         S_EXEC: begin
            exec      = 1'b1;
            req_stall = 1'b1;
         end
         default: begin
            exec      = 1'b0;
            req_stall = rsp_valid_ff & rsp_stall;
         end
      endcase
   end

   assign accept = req_valid & ~req_stall;
   assign full   = (count_ff == CNT_BITS'(DEPTH));
   assign empty  = (count_ff == '0);

   // Broadcast the command to the cells during execution
   always_comb begin
      cmd.push   = exec & (req_ff.action == ACT_PUSH) & ~full;
      cmd.pop    = exec & (req_ff.action == ACT_POP) & ~empty;
      cmd.remove = exec & (req_ff.action == ACT_REMOVE);
      cmd.id     = req_ff.task_id;
   end

   rqrm_row u_row (
      .clock (clock),
      .cmd   (cmd),
      .count (count_ff),
      .stat  (stat)
   );

   // Work out the new count and the response
   always_comb begin
      count_in          = count_ff;
      rsp_in            = rsp_ff;
      rsp_in.status     = STS_DONE;
      rsp_in.removed_id = '0;
      case (req_ff.action)
         ACT_PUSH: begin
            if (full) begin
               rsp_in.status = STS_FULL;
            end else begin
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         ACT_POP: begin
            if (empty) begin
               rsp_in.status = STS_MISS;
            end else begin
               rsp_in.removed_id = stat.head_id;
               count_in          = count_ff - CNT_BITS'(1);
            end
         end
         ACT_REMOVE: begin
            if (stat.hit) begin
               rsp_in.removed_id = stat.hit_id;
               count_in          = count_ff - CNT_BITS'(1);
            end else begin
               rsp_in.status = STS_MISS;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_in.entry_count = count_in;
      if (!exec) begin
         count_in = count_ff;
         rsp_in   = rsp_ff;
      end
   end

   // Hold the response until taken
   assign rsp_valid_in = exec | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

/* design/rqrm_checker.sv */
// rqrm_checker: port-level assertions for the ready queue, bound to the top level.
// Depends on rqrm_pkg and on ready_queue_with_remove_by_id.
`default_nettype none

module rqrm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire rqrm_pkg::rsp_type rsp
);
   import rqrm_pkg::*;

   // A taken request is answered once it has been registered and executed
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("request not answered in two cycles");

   // Count never exceeds the queue depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.entry_count <= CNT_BITS'(DEPTH))
      else $error("entry count beyond depth");

   // A full push reports a full queue and no identifier
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == STS_FULL |->
         rsp.entry_count == CNT_BITS'(DEPTH) && rsp.removed_id == '0)
      else $error("full status inconsistent");

   // A stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled response changed");

endmodule

bind ready_queue_with_remove_by_id rqrm_checker u_rqrm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire

/* dv/tb_top.sv */
// tb_top: self-checking bench for the ready queue with push, pop and remove by id.
// Runs a directed table and then random requests against a queue-based predictor.
// Depends on rqrm_pkg and ready_queue_with_remove_by_id.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rqrm_pkg::*;

   localparam int         ITEM_TARGET = 1450;
   localparam int         MAX_REPORTS = 10;
   localparam logic [1:0] ACT_IGNORED = 2'd3;

   // One line of the directed table: the request, and a hand-typed response where given
   typedef struct packed {
      req_type    rq;
      logic       typed;
      rsp_type    want;
   } dir_row_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   // Predictor state: held ids in order, head first
   logic [ID_BITS-1:0] ready_ids[$];
   rsp_type            expected_rsp[$];
   dir_row_type        dir_rows[$];
   int                 mismatch_count = 0;

   // Sender burst and receiver stall state
   int unsigned        burst_left  = 0;
   int unsigned        stall_left  = 0;
   int unsigned        stall_mode  = 0;
   logic [7:0]         stall_tick  = '0;

   ready_queue_with_remove_by_id DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the predicted queue and return the response it should give
   function automatic rsp_type apply_request(req_type r);
      rsp_type res;
      int      hit_pos;
      res.status     = STS_DONE;
      res.removed_id = '0;
      case (r.action)
         ACT_PUSH: begin
            if (ready_ids.size() >= DEPTH)
               res.status = STS_FULL;
            else
               ready_ids.push_back(r.task_id);
         end
         ACT_POP: begin
            if (ready_ids.size() == 0)
               res.status = STS_MISS;
            else
               res.removed_id = ready_ids.pop_front();
         end
         ACT_REMOVE: begin
            hit_pos = -1;
            for (int i = 0; i < ready_ids.size(); i++) begin
               if (hit_pos < 0 && ready_ids[i] == r.task_id)
                  hit_pos = i;
            end
            if (hit_pos < 0) begin
               res.status = STS_MISS;
            end else begin
               res.removed_id = ready_ids[hit_pos];
               ready_ids.delete(hit_pos);
            end
         end
         default: ;  // unused action code leaves the queue alone
      endcase
      res.entry_count = CNT_BITS'(ready_ids.size());
      return res;
   endfunction

   function automatic dir_row_type make_row(logic [1:0] act, logic [ID_BITS-1:0] id,
                                            logic typed, status_type st,
                                            logic [ID_BITS-1:0] rid, int cnt);
      dir_row_type row;
      row.rq.action        = act;
      row.rq.task_id       = id;
      row.typed            = typed;
      row.want.status      = st;
      row.want.removed_id  = rid;
      row.want.entry_count = CNT_BITS'(cnt);
      return row;
   endfunction

   // Small set of ids so that duplicates and repeat hits are common
   function automatic logic [ID_BITS-1:0] common_id();
      return ($urandom_range(0, 4) == 0) ? {ID_BITS{1'b1}} : ID_BITS'($urandom_range(0, 7));
   endfunction

   // Build one random request; the mix leans towards filling or draining the queue
   function automatic req_type pick_request(logic filling);
      req_type     r;
      int unsigned roll;
      roll      = $urandom_range(0, 99);
      r.task_id = ID_BITS'($urandom_range(0, 65535));
      if (roll < 2) begin
         r.action = ACT_IGNORED;
      end else if (roll < (filling ? 70 : 27)) begin
         r.action = ACT_PUSH;
         if ($urandom_range(0, 9) < 4)
            r.task_id = common_id();
      end else if (roll < (filling ? 80 : 60)) begin
         r.action = ACT_POP;
      end else begin
         r.action = ACT_REMOVE;
         if (ready_ids.size() != 0 && $urandom_range(0, 4) != 0)
            r.task_id = ready_ids[$urandom_range(0, ready_ids.size() - 1)];
         else if ($urandom_range(0, 1) == 0)
            r.task_id = common_id();
      end
      return r;
   endfunction

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // Hold the request until taken, then queue its expected response
   task automatic send_request(req_type r, logic typed, rsp_type want);
      int unsigned gap;
      rsp_type     predicted;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0)
            gap = $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= r;
      do @(posedge clock); while (req_stall);
      predicted = apply_request(r);
      expected_rsp.push_back(typed ? want : predicted);
   endtask

   // Compare each taken response with the oldest expectation
   task automatic check_response(rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         note_mismatch($sformatf("unexpected response status %0d id %h count %0d",
                                 got.status, got.removed_id, got.entry_count));
      end else begin
         want = expected_rsp.pop_front();
         if (got.status !== want.status)
            note_mismatch($sformatf("status exp %0d got %0d", want.status, got.status));
         if (got.removed_id !== want.removed_id)
            note_mismatch($sformatf("removed_id exp %h got %h",
                                    want.removed_id, got.removed_id));
         if (got.entry_count !== want.entry_count)
            note_mismatch($sformatf("entry_count exp %0d got %0d",
                                    want.entry_count, got.entry_count));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_response(rsp);
   end

   // Receiver stall: switch between free-running, light, heavy and periodic stalls
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_tick[2];
      endcase
      stall_tick <= stall_tick + 1'b1;
   end

   // Stimulus: directed table, then random requests, then drain
   initial begin : stimulus
      req_type     r;
      int unsigned sent;
      int unsigned phase_left;
      logic        filling;
      sent       = 0;
      phase_left = 0;
      filling    = 1'b0;

      // Empty queue: pop, remove and the unused code, then fill to the brim
      dir_rows.push_back(make_row(ACT_POP,     16'hFFFF, 1'b1, STS_MISS, 16'h0000, 0));
      dir_rows.push_back(make_row(ACT_REMOVE,  16'h0000, 1'b1, STS_MISS, 16'h0000, 0));
      dir_rows.push_back(make_row(ACT_IGNORED, 16'hFFFF, 1'b1, STS_DONE, 16'h0000, 0));
      dir_rows.push_back(make_row(ACT_PUSH,    16'h0000, 1'b1, STS_DONE, 16'h0000, 1));
      dir_rows.push_back(make_row(ACT_PUSH,    16'hFFFF, 1'b1, STS_DONE, 16'h0000, 2));
      dir_rows.push_back(make_row(ACT_PUSH,    16'h1234, 1'b0, STS_DONE, 16'h0000, 0));
      dir_rows.push_back(make_row(ACT_PUSH,    16'h1234, 1'b0, STS_DONE, 16'h0000, 0));
      for (int i = 0; i < DEPTH - 4; i++)
         dir_rows.push_back(make_row(ACT_PUSH, 16'h5A00 + 16'(i), 1'b0, STS_DONE, 16'h0000, 0));
      // Full queue, duplicate removal, missing id, and head and extreme ids out
      dir_rows.push_back(make_row(ACT_PUSH,    16'hBEEF, 1'b1, STS_FULL, 16'h0000, DEPTH));
      dir_rows.push_back(make_row(ACT_REMOVE,  16'h1234, 1'b0, STS_DONE, 16'h0000, 0));
      dir_rows.push_back(make_row(ACT_REMOVE,  16'h4321, 1'b1, STS_MISS, 16'h0000, DEPTH - 1));
      dir_rows.push_back(make_row(ACT_IGNORED, 16'h0000, 1'b1, STS_DONE, 16'h0000, DEPTH - 1));
      dir_rows.push_back(make_row(ACT_POP,     16'h8001, 1'b1, STS_DONE, 16'h0000, DEPTH - 2));
      dir_rows.push_back(make_row(ACT_REMOVE,  16'hFFFF, 1'b1, STS_DONE, 16'hFFFF, DEPTH - 3));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

      // Random part: alternate filling and draining phases
      while (sent < ITEM_TARGET) begin
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(8, 60);
         end else begin
            phase_left--;
         end
         r = pick_request(filling);
         send_request(r, 1'b0, '0);
         if (r.action != ACT_IGNORED)
            sent++;
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then wait on for stray responses
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

/* ready_queue_with_remove_by_id.f */
design/rqrm_pkg.sv
design/rqrm_cell.sv
design/rqrm_row.sv
design/ready_queue_with_remove_by_id.sv
design/rqrm_checker.sv
dv/tb_top.sv
